// ===== design/lcdnw_pkg.sv =====
// Shared types and constants for the character LCD number writer.
// Holds op codes, write-kind selects, LCD byte constants and the
// controller/datapath command and status structs.
`timescale 1ns / 1ps

package lcdnw_pkg;

  // Request op codes
  localparam logic [2:0] OP_CHAR = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_SDEC = 3'd2;
  localparam logic [2:0] OP_HEX  = 3'd3;
  localparam logic [2:0] OP_BIN  = 3'd4;
  localparam logic [2:0] OP_INIT = 3'd5;

  // Kind of bus write the datapath builds
  localparam logic [2:0] SEL_ADDR  = 3'd0;
  localparam logic [2:0] SEL_CHAR  = 3'd1;
  localparam logic [2:0] SEL_SIGN  = 3'd2;
  localparam logic [2:0] SEL_DIGIT = 3'd3;
  localparam logic [2:0] SEL_INIT  = 3'd4;

  // LCD set-up commands
  localparam logic [7:0] LCD_FUNC_SET   = 8'h38;
  localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] LCD_CLEAR      = 8'h01;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int DEC_DIGITS = 5;
  localparam int HEX_DIGITS = 4;
  localparam int BIN_DIGITS = 8;
  localparam int VAL_W      = 16;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] sel;
    logic       last;
    logic       pos_dec;
  } lcdnw_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_zero;
    logic       pos_one;
    logic       conv_done;
    logic       out_free;
  } lcdnw_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else begin
      ch = CH_UPPER_A + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ===== design/char_lcd_number_writer_top.sv =====
// Character LCD number writer: one request in, a run of LCD bus writes out.
// The first write (the cursor address) is built in the address state and then registered
// in the output register. Writes go out at one per cycle while the output is not stalled;
// digit writes also wait for the serial binary to BCD converter to finish.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register; the result channel is invalid after reset.
`timescale 1ns / 1ps

module char_lcd_number_writer_top #(
  parameter int MAX_DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic        in_row,
  input  logic [3:0]  in_column,
  input  logic [15:0] in_value,
  input  logic [4:0]  in_digit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_data,
  output logic [7:0]  out_bus_byte,
  output logic        out_last
);
  import lcdnw_pkg::*;

  lcdnw_cmd_t cmd;
  lcdnw_sts_t sts;

  lcdnw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  lcdnw_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_data    (out_is_data),
    .out_bus_byte   (out_bus_byte),
    .out_last       (out_last)
  );

endmodule

// ===== design/lcdnw_ctrl.sv =====
// Sequencer for the LCD number writer: walks one request through its
// address, character, sign, digit or set-up writes. Uses lcdnw_pkg.
`timescale 1ns / 1ps

module lcdnw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_op,
  output logic                in_stall,
  output lcdnw_pkg::lcdnw_cmd_t cmd,
  input  lcdnw_pkg::lcdnw_sts_t sts
);
  import lcdnw_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADDR   = 3'd1;
  localparam logic [2:0] ST_CHAR   = 3'd2;
  localparam logic [2:0] ST_SIGN   = 3'd3;
  localparam logic [2:0] ST_DIGITS = 3'd4;
  localparam logic [2:0] ST_INIT   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.sel     = SEL_ADDR;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_INIT) begin
            state_nxt = ST_INIT;
          end else if (in_op inside {OP_CHAR, OP_UDEC, OP_SDEC, OP_HEX, OP_BIN}) begin
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_ADDR;
          cmd.last = (sts.op inside {OP_UDEC, OP_HEX, OP_BIN}) && sts.pos_zero;
          if (sts.op == OP_CHAR) begin
            state_nxt = ST_CHAR;
          end else if (sts.op == OP_SDEC) begin
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = sts.pos_zero ? ST_IDLE : ST_DIGITS;
          end
        end
      end
      ST_CHAR: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CHAR;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_SIGN;
          cmd.last  = sts.pos_zero;
          state_nxt = sts.pos_zero ? ST_IDLE : ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        // hold until the binary to BCD conversion has finished
        if (sts.out_free && sts.conv_done) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_DIGIT;
          cmd.last    = sts.pos_one;
          cmd.pos_dec = 1'b1;
          if (sts.pos_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_INIT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_INIT;
          cmd.last    = sts.pos_one;
          cmd.pos_dec = 1'b1;
          if (sts.pos_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_digit_needs_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == SEL_DIGIT) |-> sts.conv_done)
    else $error("digit written before conversion finished");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE && in_valid))
    else $error("request loaded while busy");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("write issued into a full output register");

endmodule

// ===== design/lcdnw_dp.sv =====
// Datapath for the LCD number writer: request registers, serial
// binary to BCD converter, digit counter, byte builder and output register.
// Uses lcdnw_pkg.
`timescale 1ns / 1ps

module lcdnw_dp #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_op,
  input  logic                in_row,
  input  logic [3:0]          in_column,
  input  logic [15:0]         in_value,
  input  logic [4:0]          in_digit_count,
  input  lcdnw_pkg::lcdnw_cmd_t cmd,
  output lcdnw_pkg::lcdnw_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_is_data,
  output logic [7:0]          out_bus_byte,
  output logic                out_last
);
  import lcdnw_pkg::*;

  localparam int POS_MAX = (MAX_DIGITS > BIN_DIGITS) ? MAX_DIGITS : BIN_DIGITS;
  localparam int PW      = $clog2(POS_MAX + 1);
  localparam int BCD_W   = 4 * DEC_DIGITS;
  localparam int CW      = $clog2(VAL_W + 1);

  logic [2:0]       op_r;
  logic             row_r;
  logic [3:0]       col_r;
  logic [7:0]       char_r;
  logic             neg_r;
  logic [VAL_W-1:0] mag_r;
  logic [VAL_W-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    pos_m1;
  logic [VAL_W-1:0] mag_in;
  logic [PW-1:0]    count_sat;
  logic [3:0]       digit;
  logic [7:0]       byte_sel;
  logic             data_sel;
  logic             out_valid_r, out_valid_nxt;
  logic             out_is_data_r;
  logic [7:0]       out_bus_byte_r;
  logic             out_last_r;
  logic             out_free;

  // magnitude of the request value for each number form
  always_comb begin
    mag_in = in_value;
    if (in_op == OP_SDEC && in_value[VAL_W-1]) begin
      mag_in = VAL_W'(~in_value + 16'd1);
    end else if (in_op == OP_BIN) begin
      mag_in = {8'd0, in_value[7:0]};
    end
  end

  always_comb begin
    if (int'(in_digit_count) > MAX_DIGITS) begin
      count_sat = PW'(MAX_DIGITS);
    end else begin
      count_sat = PW'(in_digit_count);
    end
  end

  // one double-dabble step per cycle
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    sh_nxt  = sh_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      sh_nxt  = mag_in;
      bcd_nxt = '0;
      cnt_nxt = CW'(VAL_W);
    end else if (cnt_r != '0) begin
      sh_nxt  = {sh_r[VAL_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], sh_r[VAL_W-1]};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load) begin
      pos_nxt = (in_op == OP_INIT) ? PW'(4) : count_sat;
    end else if (cmd.pos_dec) begin
      pos_nxt = pos_m1;
    end
  end

  assign pos_m1 = pos_r - PW'(1);

  // digit at position pos_r - 1, zero beyond the value's size
  always_comb begin
    digit = 4'd0;
    if (op_r == OP_HEX) begin
      if (pos_m1 < PW'(HEX_DIGITS)) begin
        digit = mag_r[4*pos_m1[1:0] +: 4];
      end
    end else if (op_r == OP_BIN) begin
      if (pos_m1 < PW'(BIN_DIGITS)) begin
        digit = {3'd0, mag_r[pos_m1[2:0]]};
      end
    end else begin
      if (pos_m1 < PW'(DEC_DIGITS)) begin
        digit = bcd_r[4*pos_m1[2:0] +: 4];
      end
    end
  end

  always_comb begin
    data_sel = 1'b1;
    byte_sel = 8'd0;
    case (cmd.sel)
      SEL_ADDR: begin
        data_sel = 1'b0;
        byte_sel = {1'b1, row_r, 2'b00, col_r};
      end
      SEL_CHAR:  byte_sel = char_r;
      SEL_SIGN:  byte_sel = neg_r ? CH_MINUS : CH_PLUS;
      SEL_DIGIT: byte_sel = digit_char(digit);
      SEL_INIT: begin
        data_sel = 1'b0;
        case (pos_r[2:0])
          3'd4:    byte_sel = LCD_FUNC_SET;
          3'd3:    byte_sel = LCD_DISP_ON;
          3'd2:    byte_sel = LCD_ENTRY_MODE;
          default: byte_sel = LCD_CLEAR;
        endcase
      end
      default: begin
        data_sel = 1'b0;
        byte_sel = 8'd0;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      // drop once the transfer completes
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pos_r       <= '0;
      op_r        <= OP_CHAR;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      if (cmd.load) begin
        op_r <= in_op;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    if (cmd.load) begin
      row_r  <= in_row;
      col_r  <= in_column;
      char_r <= in_value[7:0];
      neg_r  <= in_value[VAL_W-1];
      mag_r  <= mag_in;
    end
    if (cmd.emit) begin
      out_is_data_r  <= data_sel;
      out_bus_byte_r <= byte_sel;
      out_last_r     <= cmd.last;
    end
  end

  assign sts.op        = op_r;
  assign sts.pos_zero  = (pos_r == '0);
  assign sts.pos_one   = (pos_r == PW'(1));
  assign sts.conv_done = (cnt_r == '0);
  assign sts.out_free  = out_free;

  assign out_valid    = out_valid_r;
  assign out_is_data  = out_is_data_r;
  assign out_bus_byte = out_bus_byte_r;
  assign out_last     = out_last_r;

  a_pos_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pos_dec |-> (pos_r != '0))
    else $error("digit counter decremented past zero");

  a_conv_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cnt_r == CW'(VAL_W)))
    else $error("conversion not restarted on load");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !cmd.emit) |=> (out_valid_r && $stable(out_bus_byte_r)))
    else $error("stalled write lost");

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for char_lcd_number_writer_top: queued display requests
// are driven, the expected LCD bus writes are predicted, and every write is checked.
// Depends on lcdnw_pkg for op codes and LCD byte constants.
`timescale 1ns / 1ps

module testbench;
  import lcdnw_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [7:0] LCD_LINE0_ADDR = 8'h80;
  localparam logic [7:0] LCD_LINE1_ADDR = 8'hC0;
  localparam int DIGIT_LIMIT = 16;
  localparam int RANDOM_REQS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [2:0]  op;
    logic        row;
    logic [3:0]  column;
    logic [15:0] value;
    logic [4:0]  digit_count;
    logic        wait_drain;
  } lcd_request_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic        in_row = 1'b0;
  logic [3:0]  in_column = '0;
  logic [15:0] in_value = '0;
  logic [4:0]  in_digit_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_data;
  logic [7:0]  out_bus_byte;
  logic        out_last;

  lcd_request_t pending_reqs[$];
  lcd_write_t   lcd_writes_due[$];
  logic         writes_drained = 1'b1;
  int           accepted_reqs = 0;
  int           mismatch_count = 0;
  logic         quiet_window;

  assign quiet_window = (accepted_reqs >= 90) && (accepted_reqs < 130);

  char_lcd_number_writer_top #(.MAX_DIGITS(DIGIT_LIMIT)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_data    (out_is_data),
    .out_bus_byte   (out_bus_byte),
    .out_last       (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Digit at position pos (0 = least significant); positions past the value's size read 0.
  function automatic logic [3:0] number_digit(input int unsigned mag, input int unsigned radix,
                                              input int unsigned pos);
    int unsigned v;
    v = mag;
    if (radix == 10) begin
      if (pos > 5) return 4'd0;
      for (int unsigned i = 0; i < pos; i++) v = v / 10;
      return 4'(v % 10);
    end
    if (radix == 16) begin
      if (pos >= 4) return 4'd0;
      return 4'((v >> (4 * pos)) & 15);
    end
    if (pos >= 8) return 4'd0;
    return 4'((v >> pos) & 1);
  endfunction

  task automatic predict_lcd_writes(input logic [2:0] op, input logic row, input logic [3:0] column,
                                    input logic [15:0] value, input logic [4:0] digit_count);
    lcd_write_t  writes[$];
    lcd_write_t  w;
    int unsigned mag;
    int unsigned radix;
    int unsigned ndig;
    logic [3:0]  d;
    mag = 32'(value);
    radix = 10;
    ndig = (digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : digit_count;
    if (op == OP_UNUSED_LO || op == OP_UNUSED_HI) return;
    if (op == OP_INIT) begin
      writes.push_back('{1'b0, LCD_FUNC_SET, 1'b0});
      writes.push_back('{1'b0, LCD_DISP_ON, 1'b0});
      writes.push_back('{1'b0, LCD_ENTRY_MODE, 1'b0});
      writes.push_back('{1'b0, LCD_CLEAR, 1'b0});
    end else begin
      writes.push_back('{1'b0, (row ? LCD_LINE1_ADDR : LCD_LINE0_ADDR) | {4'd0, column}, 1'b0});
      if (op == OP_CHAR) begin
        writes.push_back('{1'b1, value[7:0], 1'b0});
      end else begin
        case (op)
          OP_SDEC: begin
            if (value[15]) begin
              mag = 32'h10000 - value;
              writes.push_back('{1'b1, CH_MINUS, 1'b0});
            end else begin
              writes.push_back('{1'b1, CH_PLUS, 1'b0});
            end
          end
          OP_HEX: radix = 16;
          OP_BIN: begin
            radix = 2;
            mag = 32'(value[7:0]);
          end
          default: radix = 10;
        endcase
        for (int unsigned i = ndig; i > 0; i--) begin
          d = number_digit(mag, radix, i - 1);
          w.is_data = 1'b1;
          w.bus_byte = (d < 4'd10) ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d) - 8'd10;
          w.last = 1'b0;
          writes.push_back(w);
        end
      end
    end
    for (int i = 0; i < writes.size(); i++) begin
      w = writes[i];
      w.last = (i == writes.size() - 1);
      lcd_writes_due.push_back(w);
    end
  endtask

  task automatic add_request(input logic [2:0] op, input logic row, input logic [3:0] column,
                             input logic [15:0] value, input logic [4:0] digit_count,
                             input logic wait_drain);
    pending_reqs.push_back('{op, row, column, value, digit_count, wait_drain});
  endtask

  // Driver: advance to the next request only when idle or after a transfer.
  always @(posedge clk) begin
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) void'(pending_reqs.pop_front());
      if (!in_valid || took) begin
        if (pending_reqs.size() != 0
            && !(pending_reqs[0].wait_drain && (took || !writes_drained))
            && (quiet_window || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          in_op <= pending_reqs[0].op;
          in_row <= pending_reqs[0].row;
          in_column <= pending_reqs[0].column;
          in_value <= pending_reqs[0].value;
          in_digit_count <= pending_reqs[0].digit_count;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: one long hold-off after 40 requests, else random outside quiet window.
  always @(posedge clk) begin
    int  hold_left;
    logic hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && accepted_reqs >= 40) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      out_stall <= !quiet_window && ($urandom_range(99) < 25);
    end
  end

  // Monitor: predict on each request transfer, check each write transfer.
  always @(posedge clk) begin
    lcd_write_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_lcd_writes(in_op, in_row, in_column, in_value, in_digit_count);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (out_valid && !out_stall) begin
        if (lcd_writes_due.size() == 0) begin
          $error("unexpected write: is_data=%0d bus_byte=%02h last=%0d",
                 out_is_data, out_bus_byte, out_last);
          mismatch_count++;
        end else begin
          want = lcd_writes_due.pop_front();
          if (out_is_data !== want.is_data) begin
            $error("is_data: expected %0d, got %0d", want.is_data, out_is_data);
            mismatch_count++;
          end
          if (out_bus_byte !== want.bus_byte) begin
            $error("bus_byte: expected %02h, got %02h", want.bus_byte, out_bus_byte);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      writes_drained <= (lcd_writes_due.size() == 0);
    end
  end

  initial begin
    int          made;
    logic [2:0]  op;
    logic [15:0] value;
    logic [4:0]  cnt;

    add_request(OP_INIT, 1'b0, 4'd0, 16'h0000, 5'd0, 1'b0);
    add_request(OP_CHAR, 1'b0, 4'd0, 16'h0000, 5'd0, 1'b0);
    add_request(OP_CHAR, 1'b1, 4'd15, 16'hFFFF, 5'd31, 1'b0);
    add_request(OP_CHAR, 1'b1, 4'd9, 16'hA541, 5'd3, 1'b0);
    add_request(OP_UDEC, 1'b0, 4'd3, 16'hFFFF, 5'd16, 1'b0);
    add_request(OP_UDEC, 1'b1, 4'd5, 16'h0000, 5'd5, 1'b0);
    add_request(OP_UDEC, 1'b0, 4'd7, 16'd12345, 5'd0, 1'b0);
    add_request(OP_UDEC, 1'b1, 4'd1, 16'd54321, 5'd31, 1'b0);
    add_request(OP_SDEC, 1'b0, 4'd0, 16'h8000, 5'd6, 1'b0);
    add_request(OP_SDEC, 1'b1, 4'd2, 16'h7FFF, 5'd5, 1'b0);
    add_request(OP_SDEC, 1'b0, 4'd4, 16'hFFFF, 5'd0, 1'b0);
    add_request(OP_SDEC, 1'b1, 4'd15, 16'h0000, 5'd16, 1'b0);
    add_request(OP_SDEC, 1'b0, 4'd8, 16'hC000, 5'd17, 1'b0);
    add_request(OP_HEX, 1'b0, 4'd10, 16'hABCD, 5'd8, 1'b0);
    add_request(OP_HEX, 1'b1, 4'd11, 16'hFFFF, 5'd4, 1'b0);
    add_request(OP_HEX, 1'b0, 4'd12, 16'h1234, 5'd0, 1'b0);
    add_request(OP_HEX, 1'b1, 4'd6, 16'h09FE, 5'd20, 1'b0);
    add_request(OP_BIN, 1'b0, 4'd13, 16'hFFA5, 5'd16, 1'b0);
    add_request(OP_BIN, 1'b1, 4'd14, 16'h0001, 5'd8, 1'b0);
    add_request(OP_BIN, 1'b0, 4'd0, 16'h00FF, 5'd0, 1'b0);
    add_request(OP_UNUSED_LO, 1'b1, 4'd15, 16'hFFFF, 5'd31, 1'b0);
    add_request(OP_UNUSED_HI, 1'b0, 4'd0, 16'h0000, 5'd16, 1'b0);
    add_request(OP_INIT, 1'b1, 4'd15, 16'hFFFF, 5'd31, 1'b1);

    // Random requests; unused op codes are mixed in but not counted.
    made = 0;
    while (made < RANDOM_REQS) begin
      if ($urandom_range(99) < 5) begin
        op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end else begin
        op = 3'($urandom_range(5));
        made++;
      end
      case ($urandom_range(3))
        0: value = 16'($urandom_range(65535));
        1: value = 16'($urandom_range(255));
        2: value = $urandom_range(1) ? 16'(16'h8000 + $urandom_range(15))
                                     : 16'(16'h7FFF - $urandom_range(15));
        default: value = $urandom_range(1) ? 16'(16'hFFFF - $urandom_range(1000))
                                           : 16'($urandom_range(99999 % 65536));
      endcase
      cnt = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
      add_request(op, 1'($urandom_range(1)), 4'($urandom_range(15)), value, cnt,
                  (made % 45) == 44);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!writes_drained) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lcd_writes_due.size() != 0) begin
      $error("%0d expected writes never arrived", lcd_writes_due.size());
    end
    if (mismatch_count == 0 && lcd_writes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
